// ===== hdl/ipseq_pkg.sv =====
// Package for the ignition power sequencer: phase enumeration, response codes,
// host command characters, configuration register indexes and field widths.
// No dependencies.
`timescale 1ns / 1ps

package ipseq_pkg;

    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned DELAY_W     = 4;
    localparam int unsigned COUNT_W     = 8;
    localparam int unsigned ALIVE_W     = 3;
    localparam int unsigned RELAY_W     = 3;
    localparam int unsigned RESP_W      = 2;
    localparam int unsigned PHASE_W     = 3;
    localparam int unsigned BYTE_W      = 8;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE = 3'd0,
        PH_PON  = 3'd1,
        PH_BOOT = 3'd2,
        PH_RUN  = 3'd3,
        PH_OFF  = 3'd4
    } phase_t;

    typedef enum logic [RESP_W-1:0] {
        RESP_NONE = 2'd0,
        RESP_ACK  = 2'd1,
        RESP_NACK = 2'd2
    } resp_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEFAULT_DELAY = 3'd0,
        CFG_BOOT_WAIT     = 3'd1,
        CFG_SHUTDOWN_WAIT = 3'd2,
        CFG_HANG_WAIT     = 3'd3,
        CFG_INITIAL_IDLE  = 3'd4,
        CFG_ALIVE_LIMIT   = 3'd5,
        CFG_DEBUG_RESET   = 3'd6
    } cfg_index_t;

    localparam logic [BYTE_W-1:0] CMD_DISPLAY_ON  = 8'h31; // '1'
    localparam logic [BYTE_W-1:0] CMD_HOST_ON     = 8'h32; // '2'
    localparam logic [BYTE_W-1:0] CMD_AUX_ON      = 8'h33; // '3'
    localparam logic [BYTE_W-1:0] CMD_DISPLAY_OFF = 8'h34; // '4'
    localparam logic [BYTE_W-1:0] CMD_HOST_OFF    = 8'h35; // '5'
    localparam logic [BYTE_W-1:0] CMD_AUX_OFF     = 8'h36; // '6'
    localparam logic [BYTE_W-1:0] CMD_ALIVE       = 8'h2B; // '+'
    localparam logic [BYTE_W-1:0] CMD_SHUTDOWN    = 8'h24; // '$'
    localparam logic [BYTE_W-1:0] CMD_DEBUG       = 8'h23; // '#'
    localparam logic [BYTE_W-1:0] CMD_SET_DELAY   = 8'h2A; // '*'
    localparam logic [BYTE_W-1:0] CMD_SERVICE_ON  = 8'h21; // '!'
    localparam logic [BYTE_W-1:0] CMD_SERVICE_OFF = 8'h3F; // '?'
    localparam logic [BYTE_W-1:0] CMD_VERSION     = 8'h76; // 'v'
    localparam logic [BYTE_W-1:0] CMD_BOOT_UPPER  = 8'h55; // 'U'
    localparam logic [BYTE_W-1:0] CMD_BOOT_LOWER  = 8'h75; // 'u'

    localparam logic [BYTE_W-1:0]  DIGIT_BASE     = 8'h30;
    localparam logic [DELAY_W-1:0] DELAY_MIN      = 4'd1;
    localparam logic [DELAY_W-1:0] DELAY_MAX      = 4'd9;
    localparam logic [DELAY_W-1:0] FALLBACK_DELAY = 4'd3;
    localparam logic [COUNT_W-1:0] CANCEL_IDLE    = 8'd2;

    localparam logic [DELAY_W-1:0] RST_DEFAULT_DELAY = 4'd3;
    localparam logic [COUNT_W-1:0] RST_BOOT_WAIT     = 8'd30;
    localparam logic [COUNT_W-1:0] RST_SHUTDOWN_WAIT = 8'd15;
    localparam logic [COUNT_W-1:0] RST_HANG_WAIT     = 8'd5;
    localparam logic [COUNT_W-1:0] RST_INITIAL_IDLE  = 8'd30;
    localparam logic [ALIVE_W-1:0] RST_ALIVE_LIMIT   = 3'd3;
    localparam logic               RST_DEBUG         = 1'b1;

    localparam logic [RELAY_W-1:0] RELAY_DISPLAY = 3'b001;
    localparam logic [RELAY_W-1:0] RELAY_HOST    = 3'b010;
    localparam logic [RELAY_W-1:0] RELAY_AUX     = 3'b100;

endpackage

// ===== hdl/ignition_power_sequencer_core.sv =====
// Ignition power sequencer: input register, one-pass control update, result register.
// Depends on ipseq_pkg.
// A transfer is held in the input register and moves to the result register when the result stage advances.
// Throughput: one control pass per clock cycle while out_stall does not hold the result stage.
// Reset: asynchronous, active low; configuration returns to its defaults, the sequencer
// to idle with all relays off, and both pipeline stages empty.
`timescale 1ns / 1ps

module ignition_power_sequencer_core
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_write,
    input  logic [ipseq_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ipseq_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                second_tick,
    input  logic                                ignition_on,
    input  logic                                override_low,
    input  logic                                command_valid,
    input  logic [ipseq_pkg::BYTE_W-1:0]        command_byte,
    input  logic [ipseq_pkg::BYTE_W-1:0]        argument_byte,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ipseq_pkg::PHASE_W-1:0]       power_state,
    output logic [ipseq_pkg::RELAY_W-1:0]       relay_bits,
    output logic [ipseq_pkg::RESP_W-1:0]        response_code,
    output logic                                sleep_request,
    output logic                                bootloader_request,
    output logic [ipseq_pkg::ALIVE_W-1:0]       alive_level,
    output logic                                service_active,
    output logic                                debug_active,
    output logic [ipseq_pkg::DELAY_W-1:0]       power_on_delay
);

    import ipseq_pkg::*;

    function automatic logic [DELAY_W-1:0] clean_delay(input logic [DELAY_W-1:0] v);
        return (v >= DELAY_MIN && v <= DELAY_MAX) ? v : FALLBACK_DELAY;
    endfunction

    function automatic logic [ALIVE_W-1:0] alive_inc(input logic [ALIVE_W-1:0] v);
        return (v == {ALIVE_W{1'b1}}) ? v : v + ALIVE_W'(1);
    endfunction

    // configuration
    logic [COUNT_W-1:0] boot_wait_reg;
    logic [COUNT_W-1:0] shutdown_wait_reg;
    logic [COUNT_W-1:0] hang_wait_reg;
    logic [ALIVE_W-1:0] alive_limit_reg;

    // sequencer state
    phase_t             phase_reg,       phase_next;
    logic [RELAY_W-1:0] relays_reg,      relays_next;
    logic [DELAY_W-1:0] pon_count_reg,   pon_count_next;
    logic [COUNT_W-1:0] boot_count_reg,  boot_count_next;
    logic [COUNT_W-1:0] off_count_reg,   off_count_next;
    logic [COUNT_W-1:0] idle_count_reg,  idle_count_next;
    logic [ALIVE_W-1:0] alive_count_reg, alive_count_next;
    logic               service_reg,     service_next;
    logic               debug_reg,       debug_next;
    logic [DELAY_W-1:0] delay_reg,       delay_next;
    logic [DELAY_W-1:0] saved_delay_reg, saved_delay_next;

    // input stage
    logic               s1_valid_reg;
    logic               s1_tick_reg;
    logic               s1_ign_reg;
    logic               s1_ovr_reg;
    logic               s1_cvalid_reg;
    logic [BYTE_W-1:0]  s1_cmd_reg;
    logic [BYTE_W-1:0]  s1_arg_reg;

    // result stage
    logic               out_valid_reg;
    logic [PHASE_W-1:0] power_state_reg;
    logic [RELAY_W-1:0] relay_bits_reg;
    logic [RESP_W-1:0]  response_reg;
    logic               sleep_reg;
    logic               bootloader_reg;
    logic [ALIVE_W-1:0] alive_level_reg;
    logic               service_out_reg;
    logic               debug_out_reg;
    logic [DELAY_W-1:0] delay_out_reg;

    logic               advance;
    logic               step;
    logic               is_boot_cmd;
    logic [BYTE_W-1:0]  digit;
    logic               digit_ok;
    resp_t              resp_next;
    logic               sleep_next;
    logic               boot_req_next;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign step     = s1_valid_reg && advance;

    assign is_boot_cmd = (s1_cmd_reg == CMD_BOOT_UPPER) || (s1_cmd_reg == CMD_BOOT_LOWER);
    assign digit       = s1_arg_reg - DIGIT_BASE;
    assign digit_ok    = (digit >= BYTE_W'(DELAY_MIN)) && (digit <= BYTE_W'(DELAY_MAX));

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        relays_next      = relays_reg;
        pon_count_next   = pon_count_reg;
        boot_count_next  = boot_count_reg;
        off_count_next   = off_count_reg;
        idle_count_next  = idle_count_reg;
        alive_count_next = alive_count_reg;
        service_next     = service_reg;
        debug_next       = debug_reg;
        delay_next       = delay_reg;
        saved_delay_next = saved_delay_reg;

        // phase counters: countdowns, but the power-on counter counts up
        if (s1_tick_reg)
        begin
            if (phase_reg == PH_PON && pon_count_reg < delay_reg)
            begin
                pon_count_next = pon_count_reg + DELAY_W'(1);
            end
            else if (phase_reg == PH_RUN)
            begin
                if (alive_count_reg != '0 && !service_reg)
                    alive_count_next = alive_count_reg - ALIVE_W'(1);
            end
            else if (phase_reg == PH_OFF)
            begin
                if (off_count_reg != '0)
                    off_count_next = off_count_reg - COUNT_W'(1);
            end
            else if (phase_reg == PH_IDLE)
            begin
                if (idle_count_reg != '0)
                    idle_count_next = idle_count_reg - COUNT_W'(1);
            end
            else if (phase_reg == PH_BOOT)
            begin
                if (boot_count_reg != '0)
                    boot_count_next = boot_count_reg - COUNT_W'(1);
            end
        end

        // sequencer
        if (phase_next == PH_IDLE && s1_ign_reg)
        begin
            phase_next      = PH_PON;
            relays_next     = relays_next | RELAY_DISPLAY;
            boot_count_next = '0;
        end
        else if (phase_next == PH_PON)
        begin
            if (!s1_ign_reg)
            begin
                phase_next      = PH_IDLE;
                pon_count_next  = '0;
                boot_count_next = '0;
                idle_count_next = CANCEL_IDLE;
                relays_next     = relays_next & ~RELAY_DISPLAY;
            end
            else if (pon_count_next >= delay_reg)
            begin
                phase_next      = PH_BOOT;
                relays_next     = relays_next | RELAY_HOST;
                pon_count_next  = '0;
                boot_count_next = boot_wait_reg;
            end
        end
        else if (phase_next == PH_BOOT && boot_count_next == '0)
        begin
            pon_count_next = '0;
            if (!s1_ign_reg)
            begin
                phase_next      = PH_OFF;
                boot_count_next = '0;
            end
            else
            begin
                phase_next       = PH_RUN;
                alive_count_next = alive_inc(alive_count_next);
            end
        end
        else if (phase_next == PH_RUN)
        begin
            if (alive_count_next == '0)
            begin
                relays_next    = relays_next & ~RELAY_AUX;
                off_count_next = hang_wait_reg;
                phase_next     = PH_OFF;
            end
            else if (!s1_ign_reg)
            begin
                relays_next     = relays_next & ~RELAY_AUX;
                phase_next      = PH_OFF;
                pon_count_next  = '0;
                boot_count_next = '0;
                off_count_next  = shutdown_wait_reg;
            end
        end
        else if (phase_next == PH_OFF && off_count_next != '0)
        begin
            if (s1_ovr_reg)
                off_count_next = '0;
        end
        else if (phase_next == PH_OFF)
        begin
            relays_next     = '0;
            phase_next      = PH_IDLE;
            idle_count_next = '0;
        end

        // host command
        if (s1_cvalid_reg && !is_boot_cmd)
        begin
            case (s1_cmd_reg)
                CMD_DISPLAY_ON:
                begin
                    alive_count_next = alive_inc(alive_count_next);
                    relays_next      = relays_next | RELAY_DISPLAY;
                end
                CMD_HOST_ON:
                begin
                    alive_count_next = alive_inc(alive_count_next);
                    relays_next      = relays_next | RELAY_HOST;
                end
                CMD_AUX_ON:
                begin
                    alive_count_next = alive_inc(alive_count_next);
                    relays_next      = relays_next | RELAY_AUX;
                end
                CMD_DISPLAY_OFF:
                begin
                    relays_next = relays_next & ~RELAY_DISPLAY;
                end
                CMD_HOST_OFF:
                begin
                    alive_count_next = alive_inc(alive_count_next);
                    relays_next      = relays_next & ~RELAY_HOST;
                end
                CMD_AUX_OFF:
                begin
                    alive_count_next = alive_inc(alive_count_next);
                    relays_next      = relays_next & ~RELAY_AUX;
                end
                CMD_ALIVE:
                begin
                    alive_count_next = alive_inc(alive_count_next);
                end
                CMD_SHUTDOWN:
                begin
                    relays_next      = relays_next & ~RELAY_AUX;
                    alive_count_next = alive_inc(alive_count_next);
                    phase_next       = PH_OFF;
                    off_count_next   = shutdown_wait_reg;
                end
                CMD_DEBUG:
                begin
                    alive_count_next = alive_inc(alive_count_next);
                    debug_next       = !debug_reg;
                end
                CMD_SET_DELAY:
                begin
                    if (digit_ok)
                    begin
                        delay_next       = digit[DELAY_W-1:0];
                        saved_delay_next = digit[DELAY_W-1:0];
                    end
                    else
                    begin
                        delay_next = saved_delay_reg;
                    end
                end
                CMD_SERVICE_ON:
                begin
                    service_next = 1'b1;
                end
                CMD_SERVICE_OFF:
                begin
                    service_next = 1'b0;
                end
                default:
                begin
                end
            endcase
            if (alive_count_next > alive_limit_reg)
                alive_count_next = alive_limit_reg;
        end
    end

    // per-pass flags
    always_comb
    begin
        resp_next     = RESP_NONE;
        boot_req_next = 1'b0;
        sleep_next    = (phase_reg == PH_IDLE) && !s1_ign_reg &&
                        ((idle_count_reg == '0) ||
                         (s1_tick_reg && idle_count_reg == COUNT_W'(1)));
        if (s1_cvalid_reg)
        begin
            if (is_boot_cmd)
            begin
                boot_req_next = 1'b1;
            end
            else
            begin
                case (s1_cmd_reg) inside
                    CMD_DISPLAY_ON, CMD_HOST_ON, CMD_AUX_ON, CMD_DISPLAY_OFF,
                    CMD_HOST_OFF, CMD_AUX_OFF, CMD_ALIVE, CMD_SHUTDOWN, CMD_DEBUG,
                    CMD_SERVICE_ON, CMD_SERVICE_OFF, CMD_VERSION:
                        resp_next = RESP_ACK;
                    CMD_SET_DELAY:
                        resp_next = digit_ok ? RESP_ACK : RESP_NACK;
                    default:
                        resp_next = RESP_NACK;
                endcase
            end
        end
    end

    // configuration and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_wait_reg     <= RST_BOOT_WAIT;
            shutdown_wait_reg <= RST_SHUTDOWN_WAIT;
            hang_wait_reg     <= RST_HANG_WAIT;
            alive_limit_reg   <= RST_ALIVE_LIMIT;
            phase_reg         <= PH_IDLE;
            relays_reg        <= '0;
            pon_count_reg     <= '0;
            boot_count_reg    <= '0;
            off_count_reg     <= '0;
            idle_count_reg    <= RST_INITIAL_IDLE;
            alive_count_reg   <= '0;
            service_reg       <= 1'b0;
            debug_reg         <= RST_DEBUG;
            delay_reg         <= RST_DEFAULT_DELAY;
            saved_delay_reg   <= RST_DEFAULT_DELAY;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DEFAULT_DELAY:
                begin
                    delay_reg       <= clean_delay(cfg_data[DELAY_W-1:0]);
                    saved_delay_reg <= clean_delay(cfg_data[DELAY_W-1:0]);
                end
                CFG_BOOT_WAIT:     boot_wait_reg     <= cfg_data[COUNT_W-1:0];
                CFG_SHUTDOWN_WAIT: shutdown_wait_reg <= cfg_data[COUNT_W-1:0];
                CFG_HANG_WAIT:     hang_wait_reg     <= cfg_data[COUNT_W-1:0];
                CFG_INITIAL_IDLE:  idle_count_reg    <= cfg_data[COUNT_W-1:0];
                CFG_ALIVE_LIMIT:   alive_limit_reg   <= cfg_data[ALIVE_W-1:0];
                CFG_DEBUG_RESET:   debug_reg         <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            relays_reg      <= relays_next;
            pon_count_reg   <= pon_count_next;
            boot_count_reg  <= boot_count_next;
            off_count_reg   <= off_count_next;
            idle_count_reg  <= idle_count_next;
            alive_count_reg <= alive_count_next;
            service_reg     <= service_next;
            debug_reg       <= debug_next;
            delay_reg       <= delay_next;
            saved_delay_reg <= saved_delay_next;
        end
    end

    // input stage: hold while the result stage is full and stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_tick_reg   <= second_tick;
            s1_ign_reg    <= ignition_on;
            s1_ovr_reg    <= override_low;
            s1_cvalid_reg <= command_valid;
            s1_cmd_reg    <= command_byte;
            s1_arg_reg    <= argument_byte;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            power_state_reg <= phase_next;
            relay_bits_reg  <= relays_next;
            response_reg    <= resp_next;
            sleep_reg       <= sleep_next;
            bootloader_reg  <= boot_req_next;
            alive_level_reg <= alive_count_next;
            service_out_reg <= service_next;
            debug_out_reg   <= debug_next;
            delay_out_reg   <= delay_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign power_state        = power_state_reg;
    assign relay_bits         = relay_bits_reg;
    assign response_code      = response_reg;
    assign sleep_request      = sleep_reg;
    assign bootloader_request = bootloader_reg;
    assign alive_level        = alive_level_reg;
    assign service_active     = service_out_reg;
    assign debug_active       = debug_out_reg;
    assign power_on_delay     = delay_out_reg;

endmodule

// ===== test/ipseq_status_checker.sv =====
// Status checker for ignition_power_sequencer_core: mirrors each control pass, queues the
// predicted status of every accepted transfer and compares each result transfer with it.
// Depends on ipseq_pkg.
`timescale 1ns / 1ps

module ipseq_status_checker
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_write,
    input  logic [ipseq_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ipseq_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                second_tick,
    input  logic                                ignition_on,
    input  logic                                override_low,
    input  logic                                command_valid,
    input  logic [ipseq_pkg::BYTE_W-1:0]        command_byte,
    input  logic [ipseq_pkg::BYTE_W-1:0]        argument_byte,

    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [ipseq_pkg::PHASE_W-1:0]       power_state,
    input  logic [ipseq_pkg::RELAY_W-1:0]       relay_bits,
    input  logic [ipseq_pkg::RESP_W-1:0]        response_code,
    input  logic                                sleep_request,
    input  logic                                bootloader_request,
    input  logic [ipseq_pkg::ALIVE_W-1:0]       alive_level,
    input  logic                                service_active,
    input  logic                                debug_active,
    input  logic [ipseq_pkg::DELAY_W-1:0]       power_on_delay,

    output int                                  failures,
    output int                                  in_flight,
    output int                                  checked
);
    import ipseq_pkg::*;

    typedef struct packed {
        phase_t             state;
        logic [RELAY_W-1:0] relays;
        resp_t              resp;
        logic               sleep;
        logic               boot_req;
        logic [ALIVE_W-1:0] alive;
        logic               service;
        logic               debug;
        logic [DELAY_W-1:0] delay;
    } status_t;

    logic [COUNT_W-1:0] boot_wait;
    logic [COUNT_W-1:0] shutdown_wait;
    logic [COUNT_W-1:0] hang_wait;
    logic [ALIVE_W-1:0] alive_limit;

    phase_t             phase;
    logic [RELAY_W-1:0] relays;
    logic [DELAY_W-1:0] pon_count;
    logic [COUNT_W-1:0] boot_count;
    logic [COUNT_W-1:0] off_count;
    logic [COUNT_W-1:0] idle_count;
    logic [ALIVE_W-1:0] alive;
    logic               service;
    logic               debug;
    logic [DELAY_W-1:0] delay_s;
    logic [DELAY_W-1:0] saved_delay;

    status_t            predicted_status[$];

    function automatic logic [DELAY_W-1:0] sane_delay(input logic [DELAY_W-1:0] value);
        return (value >= DELAY_MIN && value <= DELAY_MAX) ? value : FALLBACK_DELAY;
    endfunction

    task automatic bump_alive;
        if (alive != '1)
            alive = alive + 1'b1;
    endtask

    task automatic drop_power_on;
        phase      = PH_IDLE;
        pon_count  = '0;
        boot_count = '0;
        idle_count = CANCEL_IDLE;
        relays     = relays & ~RELAY_DISPLAY;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    task automatic advance_sequencer(input logic tick, input logic ign, input logic ovr,
                                     input logic cv, input logic [BYTE_W-1:0] cmd,
                                     input logic [BYTE_W-1:0] arg, output status_t s);
        logic [BYTE_W-1:0] digit;
        resp_t             resp;
        logic              sleep;
        logic              boot_req;
        resp     = RESP_NONE;
        sleep    = 1'b0;
        boot_req = 1'b0;

        // step the current phase's counter first
        if (tick)
        begin
            if (phase == PH_PON && pon_count < delay_s)
                pon_count = pon_count + 1'b1;
            else if (phase == PH_RUN)
            begin
                if (alive != '0 && !service)
                    alive = alive - 1'b1;
            end
            else if (phase == PH_OFF)
            begin
                if (off_count != '0)
                    off_count = off_count - 1'b1;
            end
            else if (phase == PH_IDLE)
            begin
                if (idle_count != '0)
                    idle_count = idle_count - 1'b1;
            end
            else if (phase == PH_BOOT)
            begin
                if (boot_count != '0)
                    boot_count = boot_count - 1'b1;
            end
        end

        if (phase == PH_IDLE && ign)
        begin
            phase      = PH_PON;
            relays     = relays | RELAY_DISPLAY;
            boot_count = '0;
        end
        else if (phase == PH_PON && pon_count < delay_s)
        begin
            if (!ign)
                drop_power_on();
        end
        else if (phase == PH_PON)
        begin
            if (!ign)
                drop_power_on();
            else
            begin
                phase      = PH_BOOT;
                relays     = relays | RELAY_HOST;
                pon_count  = '0;
                boot_count = boot_wait;
            end
        end
        else if (phase == PH_BOOT && boot_count == '0)
        begin
            pon_count = '0;
            if (!ign)
            begin
                phase      = PH_OFF;
                boot_count = '0;
            end
            else
            begin
                phase = PH_RUN;
                bump_alive();
            end
        end
        else if (phase == PH_RUN)
        begin
            if (alive == '0)
            begin
                relays    = relays & ~RELAY_AUX;
                off_count = hang_wait;
                phase     = PH_OFF;
            end
            else if (!ign)
            begin
                relays     = relays & ~RELAY_AUX;
                phase      = PH_OFF;
                pon_count  = '0;
                boot_count = '0;
                off_count  = shutdown_wait;
            end
        end
        else if (phase == PH_OFF && off_count != '0)
        begin
            if (ovr)
                off_count = '0;
        end
        else if (phase == PH_OFF)
        begin
            relays     = '0;
            phase      = PH_IDLE;
            idle_count = '0;
        end
        else if (phase == PH_IDLE && idle_count == '0)
            sleep = 1'b1;

        // host command last
        if (cv)
        begin
            if (cmd == CMD_BOOT_UPPER || cmd == CMD_BOOT_LOWER)
                boot_req = 1'b1;
            else
            begin
                resp = RESP_ACK;
                case (cmd)
                    CMD_DISPLAY_ON:
                    begin
                        bump_alive();
                        relays = relays | RELAY_DISPLAY;
                    end
                    CMD_HOST_ON:
                    begin
                        bump_alive();
                        relays = relays | RELAY_HOST;
                    end
                    CMD_AUX_ON:
                    begin
                        bump_alive();
                        relays = relays | RELAY_AUX;
                    end
                    CMD_DISPLAY_OFF:
                        relays = relays & ~RELAY_DISPLAY;
                    CMD_HOST_OFF:
                    begin
                        bump_alive();
                        relays = relays & ~RELAY_HOST;
                    end
                    CMD_AUX_OFF:
                    begin
                        bump_alive();
                        relays = relays & ~RELAY_AUX;
                    end
                    CMD_ALIVE:
                        bump_alive();
                    CMD_SHUTDOWN:
                    begin
                        relays = relays & ~RELAY_AUX;
                        bump_alive();
                        phase     = PH_OFF;
                        off_count = shutdown_wait;
                    end
                    CMD_DEBUG:
                    begin
                        bump_alive();
                        debug = ~debug;
                    end
                    CMD_SET_DELAY:
                    begin
                        digit = arg - DIGIT_BASE;
                        if (digit >= DELAY_MIN && digit <= DELAY_MAX)
                        begin
                            delay_s     = digit[DELAY_W-1:0];
                            saved_delay = digit[DELAY_W-1:0];
                        end
                        else
                        begin
                            delay_s = saved_delay;
                            resp    = RESP_NACK;
                        end
                    end
                    CMD_SERVICE_ON:
                        service = 1'b1;
                    CMD_SERVICE_OFF:
                        service = 1'b0;
                    CMD_VERSION:
                    begin
                    end
                    default:
                        resp = RESP_NACK;
                endcase
                if (alive > alive_limit)
                    alive = alive_limit;
            end
        end

        s.state    = phase;
        s.relays   = relays;
        s.resp     = resp;
        s.sleep    = sleep;
        s.boot_req = boot_req;
        s.alive    = alive;
        s.service  = service;
        s.debug    = debug;
        s.delay    = delay_s;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        status_t want;
        if (!rst_n)
        begin
            boot_wait     = RST_BOOT_WAIT;
            shutdown_wait = RST_SHUTDOWN_WAIT;
            hang_wait     = RST_HANG_WAIT;
            alive_limit   = RST_ALIVE_LIMIT;
            phase         = PH_IDLE;
            relays        = '0;
            pon_count     = '0;
            boot_count    = '0;
            off_count     = '0;
            idle_count    = RST_INITIAL_IDLE;
            alive         = '0;
            service       = 1'b0;
            debug         = RST_DEBUG;
            delay_s       = sane_delay(RST_DEFAULT_DELAY);
            saved_delay   = delay_s;
            predicted_status.delete();
            failures      = 0;
            checked       = 0;
            in_flight     = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_status.size() == 0)
                begin
                    $error("result transfer with no control pass outstanding");
                    failures++;
                end
                else
                begin
                    want = predicted_status.pop_front();
                    check_field("power_state", want.state, power_state);
                    check_field("relay_bits", want.relays, relay_bits);
                    check_field("response_code", want.resp, response_code);
                    check_field("sleep_request", want.sleep, sleep_request);
                    check_field("bootloader_request", want.boot_req, bootloader_request);
                    check_field("alive_level", want.alive, alive_level);
                    check_field("service_active", want.service, service_active);
                    check_field("debug_active", want.debug, debug_active);
                    check_field("power_on_delay", want.delay, power_on_delay);
                    checked++;
                end
            end

            if (cfg_write)
                case (cfg_index_t'(cfg_index))
                    CFG_DEFAULT_DELAY:
                    begin
                        delay_s     = sane_delay(cfg_data[DELAY_W-1:0]);
                        saved_delay = delay_s;
                    end
                    CFG_BOOT_WAIT:
                        boot_wait = cfg_data;
                    CFG_SHUTDOWN_WAIT:
                        shutdown_wait = cfg_data;
                    CFG_HANG_WAIT:
                        hang_wait = cfg_data;
                    CFG_INITIAL_IDLE:
                        idle_count = cfg_data;
                    CFG_ALIVE_LIMIT:
                        alive_limit = cfg_data[ALIVE_W-1:0];
                    CFG_DEBUG_RESET:
                        debug = cfg_data[0];
                    default:
                    begin
                    end
                endcase

            if (in_valid && !in_stall)
            begin
                advance_sequencer(second_tick, ignition_on, override_low, command_valid,
                                  command_byte, argument_byte, want);
                predicted_status.push_back(want);
            end
            in_flight = predicted_status.size();
        end
    end

endmodule

// ===== test/ignition_power_sequencer_core_test.sv =====
// Testbench top for ignition_power_sequencer_core: drives control passes, register settings
// and idling patterns, and gives the verdict from the failure count of ipseq_status_checker.
// Depends on ipseq_pkg, ipseq_status_checker and the core.
`timescale 1ns / 1ps

module ignition_power_sequencer_core_test;
    import ipseq_pkg::*;

    localparam int WATCHDOG_LIMIT     = 2000;
    localparam int SETTING_COUNT      = 7;
    localparam int PASSES_PER_SETTING = 150;

    // one row per setting, columns in register order
    localparam logic [0:SETTING_COUNT-1][0:6][7:0] PRESETS = {
        {8'd3,   8'd30,  8'd15,  8'd5,   8'd30,  8'd3,   8'd1},
        {8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd0},
        {8'd9,   8'd255, 8'd255, 8'd255, 8'd255, 8'd7,   8'd1},
        {8'd0,   8'd2,   8'd3,   8'd1,   8'd5,   8'd0,   8'd0},
        {8'd15,  8'd5,   8'd4,   8'd2,   8'd8,   8'd2,   8'd1},
        {8'hF7,  8'h03,  8'h10,  8'h0A,  8'hFF,  8'hFC,  8'hFE},
        {8'd2,   8'd10,  8'd6,   8'd3,   8'd12,  8'd7,   8'd1}
    };

    localparam logic [0:5][BYTE_W-1:0] RELAY_CMDS = {
        CMD_DISPLAY_ON, CMD_HOST_ON, CMD_AUX_ON, CMD_DISPLAY_OFF, CMD_HOST_OFF, CMD_AUX_OFF
    };

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_write     = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   in_valid      = 1'b0;
    logic                   in_stall;
    logic                   second_tick   = 1'b0;
    logic                   ignition_on   = 1'b0;
    logic                   override_low  = 1'b0;
    logic                   command_valid = 1'b0;
    logic [BYTE_W-1:0]      command_byte  = '0;
    logic [BYTE_W-1:0]      argument_byte = '0;
    logic                   out_valid;
    logic                   out_stall     = 1'b0;
    logic [PHASE_W-1:0]     power_state;
    logic [RELAY_W-1:0]     relay_bits;
    logic [RESP_W-1:0]      response_code;
    logic                   sleep_request;
    logic                   bootloader_request;
    logic [ALIVE_W-1:0]     alive_level;
    logic                   service_active;
    logic                   debug_active;
    logic [DELAY_W-1:0]     power_on_delay;

    int failures;
    int in_flight;
    int checked;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;
    int passes_sent   = 0;

    logic ign_level = 1'b0;
    int   ign_left  = 0;
    int   tick_pct  = 50;
    int   cmd_pct   = 30;

    ignition_power_sequencer_core DUT (.*);

    ipseq_status_checker checker_i (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_pass(input logic tick, input logic ign, input logic ovr, input logic cv,
                             input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] arg);
        logic stalled;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid      <= 1'b1;
        second_tick   <= tick;
        ignition_on   <= ign;
        override_low  <= ovr;
        command_valid <= cv;
        command_byte  <= cmd;
        argument_byte <= arg;
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
        passes_sent++;
    endtask

    task automatic wait_results;
        in_valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // hold the ignition level for a stretch, with the odd glitch
    task automatic random_pass;
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] arg;
        int                pick;
        if (ign_left == 0)
        begin
            ign_level = ($urandom_range(99) < 65);
            ign_left  = $urandom_range(60, 4);
            tick_pct  = $urandom_range(90, 20);
            cmd_pct   = $urandom_range(60, 5);
        end
        ign_left--;
        pick = $urandom_range(99);
        arg  = 8'($urandom_range(255));
        if (pick < 35)
            cmd = CMD_ALIVE;
        else if (pick < 47)
            cmd = RELAY_CMDS[$urandom_range(5)];
        else if (pick < 51)
            cmd = CMD_SHUTDOWN;
        else if (pick < 56)
            cmd = CMD_DEBUG;
        else if (pick < 66)
        begin
            cmd = CMD_SET_DELAY;
            if ($urandom_range(99) < 80)
                arg = DIGIT_BASE + 8'($urandom_range(9));
        end
        else if (pick < 71)
            cmd = CMD_SERVICE_ON;
        else if (pick < 77)
            cmd = CMD_SERVICE_OFF;
        else if (pick < 80)
            cmd = CMD_VERSION;
        else if (pick < 82)
            cmd = CMD_BOOT_UPPER;
        else if (pick < 84)
            cmd = CMD_BOOT_LOWER;
        else
            cmd = 8'($urandom_range(255));
        send_pass($urandom_range(99) < tick_pct, ign_level ^ ($urandom_range(99) < 4),
                  $urandom_range(99) < 8, $urandom_range(99) < cmd_pct, cmd, arg);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pass(1'b0, 1'b0, 1'b0, 1'b1, CMD_VERSION, 8'hFF);
        send_pass(1'b0, 1'b0, 1'b0, 1'b1, CMD_DEBUG, 8'h00);
        send_pass(1'b0, 1'b0, 1'b0, 1'b1, CMD_SERVICE_ON, 8'h00);
        send_pass(1'b0, 1'b0, 1'b0, 1'b1, CMD_SERVICE_OFF, 8'h00);
        send_pass(1'b0, 1'b0, 1'b0, 1'b1, CMD_SET_DELAY, DIGIT_BASE);
        send_pass(1'b0, 1'b0, 1'b0, 1'b1, CMD_SET_DELAY, DIGIT_BASE + 8'd9);
        send_pass(1'b0, 1'b0, 1'b0, 1'b1, CMD_SET_DELAY, 8'hFF);
        send_pass(1'b0, 1'b0, 1'b0, 1'b1, CMD_SET_DELAY, 8'h00);
        send_pass(1'b0, 1'b0, 1'b0, 1'b1, CMD_SET_DELAY, DIGIT_BASE + 8'd10);
        send_pass(1'b0, 1'b0, 1'b0, 1'b1, CMD_SET_DELAY, DIGIT_BASE + 8'd1);
        send_pass(1'b0, 1'b0, 1'b0, 1'b1, CMD_BOOT_UPPER, 8'h00);
        send_pass(1'b0, 1'b0, 1'b0, 1'b1, CMD_BOOT_LOWER, 8'h00);
        send_pass(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00);
        send_pass(1'b0, 1'b0, 1'b0, 1'b1, 8'hFF, 8'hFF);
        for (int k = 0; k < 6; k++)
            send_pass(1'b1, 1'b0, 1'b0, 1'b1, RELAY_CMDS[k], 8'h00);
        send_pass(1'b1, 1'b0, 1'b0, 1'b1, CMD_ALIVE, 8'h00);
        send_pass(1'b0, 1'b0, 1'b0, 1'b1, CMD_SHUTDOWN, 8'h00);
        send_pass(1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00);
        send_pass(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00);
        send_pass(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00);
        send_pass(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00);

        for (int s = 0; s < SETTING_COUNT; s++)
        begin
            wait_results();
            write_reg(CFG_DEFAULT_DELAY, PRESETS[s][CFG_DEFAULT_DELAY]);
            write_reg(CFG_BOOT_WAIT, PRESETS[s][CFG_BOOT_WAIT]);
            write_reg(CFG_SHUTDOWN_WAIT, PRESETS[s][CFG_SHUTDOWN_WAIT]);
            write_reg(CFG_HANG_WAIT, PRESETS[s][CFG_HANG_WAIT]);
            write_reg(CFG_INITIAL_IDLE, PRESETS[s][CFG_INITIAL_IDLE]);
            write_reg(CFG_ALIVE_LIMIT, PRESETS[s][CFG_ALIVE_LIMIT]);
            write_reg(CFG_DEBUG_RESET, PRESETS[s][CFG_DEBUG_RESET]);
            case (s % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 87;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 87;
                end
                default:
                begin
                    send_idle_pct = 17;
                    stall_pct     = 17;
                end
            endcase
            repeat (PASSES_PER_SETTING) random_pass();
        end
        wait_results();

        $display("Covered %0d control passes and %0d checked results over %0d register settings,",
                 passes_sent, checked, SETTING_COUNT);
        $display("with free flow, sender gaps, receiver stalls and both together.");
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
